/* rtl/fhtg_pkg.sv */
// ----------------------------------------------------------------------------
// fhtg_pkg
// Shared types, constants and the quarter-wave sine table generator for the
// four harmonic tone generator.
// ----------------------------------------------------------------------------
package fhtg_pkg;

	// Default parameter values
	localparam int PHASE_BITS_DEF = 32;
	localparam int SINE_ADDR_BITS_DEF = 10;

	// Configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVERTONE_WEIGHT = 2'd2;

	// Register widths and reset values
	localparam int STEP_W = 32;
	localparam int AMP_W = 15;
	localparam int WEIGHT_W = 9;
	localparam logic [STEP_W-1:0] PHASE_STEP_RST = 32'd25480064;
	localparam logic [AMP_W-1:0] AMPLITUDE_RST = 15'd20000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd128;

	// Datapath widths and constants
	localparam int TABLE_W = 15;
	localparam int SAMPLE_W = 16;
	localparam int ACC_W = 28;
	localparam int MAG_W = 26;
	localparam int GAIN_W = 31;
	localparam int PROD_W = MAG_W + GAIN_W;
	localparam int OUT_SHIFT = 39;
	localparam int RES_W = PROD_W - OUT_SHIFT;
	localparam logic [15:0] TWO_THIRDS_Q16 = 16'd43691;
	localparam logic [RES_W-1:0] POS_LIMIT = 18'd32767;
	localparam logic [RES_W-1:0] NEG_LIMIT = 18'd32768;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// Harmonic selector codes
	localparam logic [1:0] HARM_FUND = 2'd0;
	localparam logic [1:0] HARM_SECOND = 2'd1;
	localparam logic [1:0] HARM_THIRD = 2'd2;
	localparam logic [1:0] HARM_LAST = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_MUL,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       start;
		logic       issue;
		logic [1:0] harm;
		logic       abs_en;
		logic       mul_en;
		logic       emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic acc_done;
		logic out_free;
	} status_t;

	// One entry of the quarter-wave Q15 sine table, odd Taylor series in
	// Horner form over Q30 integers.
	function automatic logic [TABLE_W-1:0] sine_entry(input int unsigned k,
		input int abits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned e;
		longint unsigned one;
		one = 64'd1 << 30;
		x = (64'(k) * 64'd1686629713) >> abits;
		x2 = (x * x) >> 30;
		t = one;
		t = one - ((x2 * t) >> 30) / 64'd210;
		t = one - ((x2 * t) >> 30) / 64'd156;
		t = one - ((x2 * t) >> 30) / 64'd110;
		t = one - ((x2 * t) >> 30) / 64'd72;
		t = one - ((x2 * t) >> 30) / 64'd42;
		t = one - ((x2 * t) >> 30) / 64'd20;
		t = one - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		e = (s * 64'd32767 + (one >> 1)) >> 30;
		if (e > 64'd32767) begin
			e = 64'd32767;
		end
		return TABLE_W'(e);
	endfunction

endpackage

/* rtl/four_harmonic_tone_generator_core.sv */
// ----------------------------------------------------------------------------
// four_harmonic_tone_generator_core
// Additive DDS tone: fundamental plus weighted 2nd..4th harmonics per sample.
// Each request steps through the four ROM lookups, accumulation, magnitude,
// the two-step gain multiply and saturation into the output register; no new
// request is taken until then. The single sine ROM port is read four times per sample.
// Reset (arst_n low): phase cleared, registers to defaults, no result held.
// ----------------------------------------------------------------------------
module four_harmonic_tone_generator_core #(
	parameter int PHASE_BITS = fhtg_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_ADDR_BITS = fhtg_pkg::SINE_ADDR_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fhtg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fhtg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fhtg_pkg::SAMPLE_W-1:0] sample,
	output logic                                 clipped
);

	fhtg_pkg::cmd_t    cmd;
	fhtg_pkg::status_t status;

	// Sequencer
	fhtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and storage
	fhtg_datapath #(
		.PHASE_BITS           (PHASE_BITS),
		.SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (restart),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.clipped   (clipped)
	);

	// Hold off new requests once one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// Load the output register only when it is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result overwrote a pending result");

	// Clip flag goes with a rail value
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (sample == fhtg_pkg::SAMPLE_MAX ||
		sample == fhtg_pkg::SAMPLE_MIN))
		else $error("clip flag without saturated sample");

endmodule

/* rtl/fhtg_ctrl.sv */
// ----------------------------------------------------------------------------
// fhtg_ctrl
// Sequencer: takes a request, issues the four harmonic lookups, then steps
// the scaling datapath and hands the sample to the output register.
// ----------------------------------------------------------------------------
module fhtg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fhtg_pkg::status_t  status,
	output fhtg_pkg::cmd_t     cmd
);

	fhtg_pkg::state_t state_q, state_d;
	logic [1:0] cnt_q, cnt_d;

	// State and harmonic counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fhtg_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.harm = cnt_q;
		in_ready = 1'b0;
		unique case (state_q)
			fhtg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					cnt_d = fhtg_pkg::HARM_FUND;
					state_d = fhtg_pkg::ST_ISSUE;
				end
			end
			fhtg_pkg::ST_ISSUE: begin
				cmd.issue = 1'b1;
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == fhtg_pkg::HARM_LAST) begin
					state_d = fhtg_pkg::ST_WAIT;
				end
			end
			fhtg_pkg::ST_WAIT: begin
				if (status.acc_done) begin
					cmd.abs_en = 1'b1;
					state_d = fhtg_pkg::ST_MUL;
				end
			end
			fhtg_pkg::ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d = fhtg_pkg::ST_EMIT;
			end
			fhtg_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d = fhtg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fhtg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/fhtg_datapath.sv */
// ----------------------------------------------------------------------------
// fhtg_datapath
// Configuration registers, phase accumulator, sine ROM lookup pipeline,
// harmonic accumulator, gain multiplier, saturation and output register.
// ----------------------------------------------------------------------------
module fhtg_datapath #(
	parameter int PHASE_BITS = fhtg_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_ADDR_BITS = fhtg_pkg::SINE_ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fhtg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fhtg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                restart,
	input  fhtg_pkg::cmd_t                      cmd,
	output fhtg_pkg::status_t                   status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fhtg_pkg::SAMPLE_W-1:0] sample,
	output logic                                clipped
);

	localparam int A = SINE_TABLE_ADDR_BITS;
	localparam int QLEN = 1 << A;
	localparam int TW = fhtg_pkg::TABLE_W;
	localparam int AW = fhtg_pkg::ACC_W;

	typedef logic [TW-1:0] rom_t [QLEN+1];

	function automatic rom_t build_rom();
		rom_t tbl;
		for (int k = 0; k <= QLEN; k++) begin
			tbl[k] = fhtg_pkg::sine_entry(k, A);
		end
		return tbl;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Configuration registers
	logic [fhtg_pkg::STEP_W-1:0]   step_q;
	logic [fhtg_pkg::AMP_W-1:0]    amp_q;
	logic [fhtg_pkg::WEIGHT_W-1:0] weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= fhtg_pkg::PHASE_STEP_RST;
			amp_q <= fhtg_pkg::AMPLITUDE_RST;
			weight_q <= fhtg_pkg::WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fhtg_pkg::REG_PHASE_STEP: step_q <= cfg_data[fhtg_pkg::STEP_W-1:0];
				fhtg_pkg::REG_AMPLITUDE: amp_q <= cfg_data[fhtg_pkg::AMP_W-1:0];
				fhtg_pkg::REG_OVERTONE_WEIGHT: weight_q <= cfg_data[fhtg_pkg::WEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Gain product, refreshed every cycle from the amplitude register
	logic [fhtg_pkg::GAIN_W-1:0] gain_q;

	always_ff @(posedge clk) begin
		gain_q <= fhtg_pkg::GAIN_W'(amp_q) * fhtg_pkg::GAIN_W'(fhtg_pkg::TWO_THIRDS_Q16);
	end

	// Phase accumulator: clear on restart, latch sample phase, advance
	logic [PHASE_BITS-1:0] phase_q, base_q, triple_q, cur_phase;

	assign cur_phase = restart ? '0 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.start) begin
			phase_q <= cur_phase + PHASE_BITS'(step_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			base_q <= cur_phase;
			triple_q <= cur_phase + {cur_phase[PHASE_BITS-2:0], 1'b0};
		end
	end

	// Stage 1: harmonic phase to table address and sign
	logic [PHASE_BITS-1:0] hphase;
	logic [A+1:0]          top_bits;
	logic [A-1:0]          k_idx;
	logic [A:0]            addr_s1;
	logic                  neg_s1, first_s1, last_s1, v_s1;

	always_comb begin
		unique case (cmd.harm)
			fhtg_pkg::HARM_FUND: hphase = base_q;
			fhtg_pkg::HARM_SECOND: hphase = {base_q[PHASE_BITS-2:0], 1'b0};
			fhtg_pkg::HARM_THIRD: hphase = triple_q;
			fhtg_pkg::HARM_LAST: hphase = {base_q[PHASE_BITS-3:0], 2'b00};
		endcase
	end

	assign top_bits = hphase[PHASE_BITS-1 -: A+2];
	assign k_idx = top_bits[A-1:0];

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			addr_s1 <= top_bits[A] ? ((A+1)'(QLEN) - {1'b0, k_idx}) : {1'b0, k_idx};
			neg_s1 <= top_bits[A+1];
			first_s1 <= (cmd.harm == fhtg_pkg::HARM_FUND);
			last_s1 <= (cmd.harm == fhtg_pkg::HARM_LAST);
		end
	end

	// Stage 2: registered ROM read
	logic [TW-1:0] rom_s2;
	logic          neg_s2, first_s2, last_s2, v_s2;

	always_ff @(posedge clk) begin
		rom_s2 <= SINE_ROM[addr_s1];
		neg_s2 <= neg_s1;
		first_s2 <= first_s1;
		last_s2 <= last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// Stage 3: weight and accumulate
	logic signed [15:0]   sval;
	logic signed [AW-1:0] term;
	logic signed [AW-1:0] acc_q;
	logic                 done_q;

	always_comb begin
		sval = neg_s2 ? -$signed({1'b0, rom_s2}) : $signed({1'b0, rom_s2});
		if (first_s2) begin
			term = AW'(sval) <<< 8;
		end else begin
			term = AW'(sval) * AW'($signed({1'b0, weight_q}));
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s2 & last_s2;
		end
	end

	// Magnitude, then magnitude times gain
	logic [fhtg_pkg::MAG_W-1:0]  mag_q;
	logic                        neg_q;
	logic [fhtg_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (cmd.abs_en) begin
			mag_q <= acc_q[AW-1] ? fhtg_pkg::MAG_W'(-acc_q) : fhtg_pkg::MAG_W'(acc_q);
			neg_q <= acc_q[AW-1];
		end
		if (cmd.mul_en) begin
			prod_q <= fhtg_pkg::PROD_W'(mag_q) * fhtg_pkg::PROD_W'(gain_q);
		end
	end

	// Truncate toward zero, saturate
	logic [fhtg_pkg::RES_W-1:0]           res_mag;
	logic signed [fhtg_pkg::SAMPLE_W-1:0] sat_val;
	logic                                 sat_hit;

	always_comb begin
		res_mag = prod_q[fhtg_pkg::PROD_W-1:fhtg_pkg::OUT_SHIFT];
		if (neg_q) begin
			sat_hit = res_mag > fhtg_pkg::NEG_LIMIT;
			sat_val = sat_hit ? fhtg_pkg::SAMPLE_MIN
				: fhtg_pkg::SAMPLE_W'(fhtg_pkg::RES_W'(0) - res_mag);
		end else begin
			sat_hit = res_mag > fhtg_pkg::POS_LIMIT;
			sat_val = sat_hit ? fhtg_pkg::SAMPLE_MAX : fhtg_pkg::SAMPLE_W'(res_mag);
		end
	end

	// Output register
	logic                                 out_valid_q;
	logic signed [fhtg_pkg::SAMPLE_W-1:0] sample_q;
	logic                                 clipped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sample_q <= sat_val;
			clipped_q <= sat_hit;
		end
	end

	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign clipped = clipped_q;
	assign status.acc_done = done_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule
